// ===== rtl/lcde_pkg.sv =====
// ----------------------------------------------------------------------------
// lcde_pkg
// Types, codes and widths shared by the L1 centroid distance engine files.
// ----------------------------------------------------------------------------
package lcde_pkg;

	localparam int VALUE_W    = 32;
	localparam int SUM_W      = 48;
	localparam int CCNT_W     = 5;
	localparam int COLC_W     = 9;
	localparam int CCC_W      = 9;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0] FUNC_ADD_NODE = 3'd0;
	localparam logic [2:0] FUNC_ADD_VEC  = 3'd1;
	localparam logic [2:0] FUNC_MEASURE  = 3'd2;
	localparam logic [2:0] FUNC_START    = 3'd3;
	localparam logic [2:0] FUNC_FINISH   = 3'd4;

	localparam logic [1:0] REG_CLUSTER_COUNT        = 2'd0;
	localparam logic [1:0] REG_COLUMN_COUNT         = 2'd1;
	localparam logic [1:0] REG_BICLUSTER_MODE       = 2'd2;
	localparam logic [1:0] REG_COLUMN_CLUSTER_COUNT = 2'd3;

	typedef struct packed {
		logic [2:0]                func;
		logic [3:0]                cluster;
		logic [7:0]                column;
		logic signed [VALUE_W-1:0] value;
		logic                      has_value;
		logic                      last;
		logic                      column_clustered;
	} in_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] distance;
		logic             empty_cluster;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic cnt_upd;
		logic rd;
		logic wr_sum;
		logic div_cent;
		logic div_bi;
		logic acc_upd;
		logic res_load;
		logic start_clr;
		logic swap;
		logic sweep_all;
		logic sweep_bank;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       last;
		logic       need_rd;
		logic       cnt_zero;
		logic       bi;
		logic       div_done;
		logic       out_busy;
		logic       sweep_end_all;
		logic       sweep_end_bank;
	} sts_t;

endpackage

// ===== rtl/lcde_if.sv =====
// ----------------------------------------------------------------------------
// lcde_req_if / lcde_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface lcde_req_if;
	logic               valid;
	logic               ready;
	lcde_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lcde_rsp_if;
	logic                valid;
	logic                ready;
	lcde_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/l1_centroid_distance_engine.sv =====
// ----------------------------------------------------------------------------
// l1_centroid_distance_engine
// K-means kernel: banked column sums and member counts with L1 distance.
// ----------------------------------------------------------------------------
// Request words arrive on req (valid/ready) and carry one element, a start or
// a finish. A measure word with last set produces one result word on rsp;
// no other word produces a result. Settings are written over the APB port;
// the user must do so only while the engine is idle, as the block does not
// enforce it. pready is always high. Words are handled one at a time. An add
// word with an element reads the memory, then writes the sum back. A measure
// element passes through the 48-step radix-2 divider that forms the centroid;
// the last word of a vector in bicluster mode, if its cluster is not empty,
// goes through the same divider again for the scaling division. A start word
// sweeps the next bank of the sum memory; a finish word swaps the banks once
// a node has been added.
// After reset the engine clears the whole sum memory, both banks, with
// req.ready low.
// A finished result sits in the output register until rsp takes it; the
// engine keeps accepting words and only stalls when a second result is
// ready before the first has been taken.
// ----------------------------------------------------------------------------
module l1_centroid_distance_engine #(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_COLUMNS  = 256,
	parameter int COUNT_BITS   = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lcde_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [lcde_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [lcde_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	lcde_req_if.sink                            req,
	lcde_rsp_if.source                          rsp
);
	// Configuration registers.
	logic [lcde_pkg::CCNT_W-1:0] cluster_count_q;
	logic [lcde_pkg::COLC_W-1:0] column_count_q;
	logic                        bicluster_mode_q;
	logic [lcde_pkg::CCC_W-1:0]  column_cluster_count_q;
	logic                        cfg_wr;

	lcde_pkg::cmd_t cmd;
	lcde_pkg::sts_t sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q        <= lcde_pkg::CCNT_W'(16);
			column_count_q         <= lcde_pkg::COLC_W'(256);
			bicluster_mode_q       <= 1'b0;
			column_cluster_count_q <= lcde_pkg::CCC_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lcde_pkg::REG_CLUSTER_COUNT:
					cluster_count_q <= pwdata[lcde_pkg::CCNT_W-1:0];
				lcde_pkg::REG_COLUMN_COUNT:
					column_count_q <= pwdata[lcde_pkg::COLC_W-1:0];
				lcde_pkg::REG_BICLUSTER_MODE:
					bicluster_mode_q <= pwdata[0];
				lcde_pkg::REG_COLUMN_CLUSTER_COUNT:
					column_cluster_count_q <= pwdata[lcde_pkg::CCC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lcde_pkg::REG_CLUSTER_COUNT:
				prdata = lcde_pkg::CFG_DATA_W'(cluster_count_q);
			lcde_pkg::REG_COLUMN_COUNT:
				prdata = lcde_pkg::CFG_DATA_W'(column_count_q);
			lcde_pkg::REG_BICLUSTER_MODE:
				prdata = lcde_pkg::CFG_DATA_W'(bicluster_mode_q);
			lcde_pkg::REG_COLUMN_CLUSTER_COUNT:
				prdata = lcde_pkg::CFG_DATA_W'(column_cluster_count_q);
			default:
				prdata = '0;
		endcase
	end

	// The controller sequences each word; the datapath holds the bank state, counts and sums.
	lcde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcde_dp #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_COLUMNS  (MAX_COLUMNS),
		.COUNT_BITS   (COUNT_BITS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_item              (req.data),
		.cluster_count        (cluster_count_q),
		.column_count         (column_count_q),
		.bicluster_mode       (bicluster_mode_q),
		.column_cluster_count (column_cluster_count_q),
		.cmd                  (cmd),
		.sts                  (sts),
		.out_item             (rsp.data),
		.out_valid            (rsp.valid),
		.out_ready            (rsp.ready)
	);

	// A word is decoded in the cycle after it is taken, so ready drops.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while the previous word is in work");

	// An empty cluster always reports a zero distance.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.empty_cluster) |-> (rsp.data.distance == '0))
		else $error("empty cluster result with nonzero distance");

	// A result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !rsp.valid)
		else $error("result register overwritten before it was taken");
endmodule

// ===== rtl/lcde_ram.sv =====
// ----------------------------------------------------------------------------
// lcde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lcde_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/lcde_div.sv =====
// ----------------------------------------------------------------------------
// lcde_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcde_div #(
	parameter int DVS_W = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lcde_pkg::SUM_W-1:0] dividend,
	input  logic [DVS_W-1:0]           divisor,
	output logic                       done,
	output logic [lcde_pkg::SUM_W-1:0] quotient
);
	localparam int N     = lcde_pkg::SUM_W;
	localparam int CNT_W = $clog2(N + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [N-1:0]     quo_q;
	logic [DVS_W:0]   sh;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign sh   = {rem_q, quo_q[N-1]};
	assign diff = sh - {1'b0, dvs_q};
	assign ge   = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/lcde_dp.sv =====
// ----------------------------------------------------------------------------
// lcde_dp
// Datapath: item register, bank state, counts, sum memory, divider,
// distance accumulator and result register.
// ----------------------------------------------------------------------------
module lcde_dp #(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_COLUMNS  = 256,
	parameter int COUNT_BITS   = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lcde_pkg::in_item_t                in_item,
	input  logic [lcde_pkg::CCNT_W-1:0]       cluster_count,
	input  logic [lcde_pkg::COLC_W-1:0]       column_count,
	input  logic                              bicluster_mode,
	input  logic [lcde_pkg::CCC_W-1:0]        column_cluster_count,
	input  lcde_pkg::cmd_t                    cmd,
	output lcde_pkg::sts_t                    sts,
	output lcde_pkg::out_item_t               out_item,
	output logic                              out_valid,
	input  logic                              out_ready
);
	localparam int SUM_W  = lcde_pkg::SUM_W;
	localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ADDR_W = 1 + CL_W + COL_W;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam int DVS_W  = (COUNT_BITS > lcde_pkg::CCC_W) ? COUNT_BITS : lcde_pkg::CCC_W;

	lcde_pkg::in_item_t  item_q;
	lcde_pkg::out_item_t res_q;
	logic                res_valid_q;
	logic                cur_q;
	logic                node_added_q;
	logic [SUM_W-1:0]    acc_q;
	logic                sum_neg_q;
	logic [ADDR_W-1:0]   sw_q;
	logic [COUNT_BITS-1:0] cnt_q [2][MAX_CLUSTERS];

	logic              nb;
	logic              cl_ok;
	logic              col_ok;
	logic [CL_W-1:0]   cl_idx;
	logic [COL_W-1:0]  col_idx;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic              cnt_zero;
	logic              is_meas;
	logic              need_rd;
	logic [ADDR_W-1:0] item_addr;
	logic [ADDR_W-1:0] sweep_addr;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [SUM_W-1:0]  ram_wdata;
	logic [SUM_W-1:0]  rdata;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_sat;
	logic [SUM_W-1:0]  sum_mag;
	logic              div_start;
	logic [SUM_W-1:0]  div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	logic              div_done;
	logic [SUM_W-1:0]  quotient;
	logic [SUM_W+1:0]  avg;
	logic [SUM_W+1:0]  dlt;
	logic [SUM_W+1:0]  adlt;
	logic [SUM_W+1:0]  acc_sum;
	logic [SUM_W-1:0]  acc_next;

	assign nb      = ~cur_q;
	assign cl_idx  = CL_W'(item_q.cluster);
	assign col_idx = COL_W'(item_q.column);
	assign cl_ok   = ({1'b0, item_q.cluster} < cluster_count)
		&& (32'(item_q.cluster) < 32'(MAX_CLUSTERS));
	assign col_ok  = ({1'b0, item_q.column} < column_count)
		&& (32'(item_q.column) < 32'(MAX_COLUMNS));
	assign cnt_cur  = cl_ok ? cnt_q[cur_q][cl_idx] : '0;
	assign cnt_zero = (cnt_cur == '0);
	assign is_meas  = (item_q.func == lcde_pkg::FUNC_MEASURE);

	always_comb begin
		if (is_meas) begin
			need_rd = !cnt_zero && item_q.has_value && col_ok
				&& (!bicluster_mode || item_q.column_clustered);
		end else begin
			need_rd = cl_ok && item_q.has_value && col_ok;
		end
	end

	assign item_addr  = {(is_meas ? cur_q : nb), cl_idx, col_idx};
	assign sweep_addr = cmd.sweep_all ? sw_q : {nb, sw_q[ADDR_W-2:0]};

	// Saturating add of the element into the stored sum.
	assign sum_ext = {rdata[SUM_W-1], rdata}
		+ {{(SUM_W + 1 - lcde_pkg::VALUE_W){item_q.value[lcde_pkg::VALUE_W-1]}},
		item_q.value};
	always_comb begin
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
				: {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	assign ram_we    = cmd.wr_sum | cmd.sweep_all | cmd.sweep_bank;
	assign ram_waddr = cmd.wr_sum ? item_addr : sweep_addr;
	assign ram_wdata = cmd.wr_sum ? sum_sat : '0;

	lcde_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (item_addr),
		.rdata (rdata)
	);

	// One divider serves the centroid and the final bicluster scaling.
	assign sum_mag   = rdata[SUM_W-1] ? (~rdata + 1'b1) : rdata;
	assign div_start = cmd.div_cent | cmd.div_bi;
	always_comb begin
		if (cmd.div_bi) begin
			div_dividend = acc_q;
			div_divisor  = (column_cluster_count == '0) ? DVS_W'(1)
				: DVS_W'(column_cluster_count);
		end else begin
			div_dividend = sum_mag;
			div_divisor  = DVS_W'(cnt_cur);
		end
	end

	lcde_div #(
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// |value - centroid|, added with saturation.
	assign avg  = sum_neg_q ? (~{2'b00, quotient} + 1'b1) : {2'b00, quotient};
	assign dlt  = {{(SUM_W + 2 - lcde_pkg::VALUE_W){item_q.value[lcde_pkg::VALUE_W-1]}},
		item_q.value} - avg;
	assign adlt = dlt[SUM_W+1] ? (~dlt + 1'b1) : dlt;
	assign acc_sum  = {2'b00, acc_q} + adlt;
	assign acc_next = (acc_sum[SUM_W+1:SUM_W] != 2'b00) ? '1 : acc_sum[SUM_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.div_cent) begin
			sum_neg_q <= rdata[SUM_W-1];
		end
		if (cmd.res_load) begin
			res_q.empty_cluster <= cnt_zero;
			if (cnt_zero) begin
				res_q.distance <= '0;
			end else if (bicluster_mode) begin
				res_q.distance <= quotient;
			end else begin
				res_q.distance <= acc_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			cur_q        <= 1'b0;
			node_added_q <= 1'b0;
			acc_q        <= '0;
			sw_q         <= '0;
			cnt_q        <= '{default: '0};
		end else begin
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cmd.cnt_upd) begin
				if (item_q.func == lcde_pkg::FUNC_ADD_NODE) begin
					node_added_q <= 1'b1;
				end
				if (cl_ok && item_q.last && (cnt_q[nb][cl_idx] != '1)) begin
					cnt_q[nb][cl_idx] <= cnt_q[nb][cl_idx] + 1'b1;
				end
			end
			if (cmd.acc_upd) begin
				acc_q <= acc_next;
			end
			if (cmd.res_load) begin
				acc_q <= '0;
			end
			if (cmd.start_clr) begin
				for (int i = 0; i < MAX_CLUSTERS; i++) begin
					cnt_q[nb][i] <= '0;
				end
				node_added_q <= 1'b0;
				acc_q        <= '0;
				sw_q         <= '0;
			end
			if (cmd.sweep_all || cmd.sweep_bank) begin
				sw_q <= sw_q + 1'b1;
			end
			if (cmd.swap && node_added_q) begin
				cur_q <= ~cur_q;
			end
		end
	end

	assign sts.func           = item_q.func;
	assign sts.last           = item_q.last;
	assign sts.need_rd        = need_rd;
	assign sts.cnt_zero       = cnt_zero;
	assign sts.bi             = bicluster_mode;
	assign sts.div_done       = div_done;
	assign sts.out_busy       = res_valid_q;
	assign sts.sweep_end_all  = &sw_q;
	assign sts.sweep_end_bank = &sw_q[ADDR_W-2:0];

	assign out_item  = res_q;
	assign out_valid = res_valid_q;
endmodule

// ===== rtl/lcde_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcde_ctrl
// Controller state machine sequencing one request word at a time.
// ----------------------------------------------------------------------------
module lcde_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lcde_pkg::sts_t sts,
	output lcde_pkg::cmd_t cmd
);
	typedef enum logic [9:0] {
		ST_CLR_ALL  = 10'b00_0000_0001,
		ST_IDLE     = 10'b00_0000_0010,
		ST_DECODE   = 10'b00_0000_0100,
		ST_RD       = 10'b00_0000_1000,
		ST_USE      = 10'b00_0001_0000,
		ST_DIVC     = 10'b00_0010_0000,
		ST_POST     = 10'b00_0100_0000,
		ST_DIVB     = 10'b00_1000_0000,
		ST_RES      = 10'b01_0000_0000,
		ST_CLR_BANK = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLR_ALL: begin
				cmd.sweep_all = 1'b1;
				if (sts.sweep_end_all) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.func) inside
					lcde_pkg::FUNC_ADD_NODE, lcde_pkg::FUNC_ADD_VEC: begin
						cmd.cnt_upd = 1'b1;
						state_d     = sts.need_rd ? ST_RD : ST_IDLE;
					end
					lcde_pkg::FUNC_MEASURE: begin
						state_d = sts.need_rd ? ST_RD : ST_POST;
					end
					lcde_pkg::FUNC_START: begin
						cmd.start_clr = 1'b1;
						state_d       = ST_CLR_BANK;
					end
					lcde_pkg::FUNC_FINISH: begin
						cmd.swap = 1'b1;
						state_d  = ST_IDLE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_USE;
			end
			ST_USE: begin
				if (sts.func == lcde_pkg::FUNC_MEASURE) begin
					cmd.div_cent = 1'b1;
					state_d      = ST_DIVC;
				end else begin
					cmd.wr_sum = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_DIVC: begin
				if (sts.div_done) begin
					cmd.acc_upd = 1'b1;
					state_d     = ST_POST;
				end
			end
			ST_POST: begin
				if (!sts.last) begin
					state_d = ST_IDLE;
				end else if (!sts.cnt_zero && sts.bi) begin
					cmd.div_bi = 1'b1;
					state_d    = ST_DIVB;
				end else begin
					state_d = ST_RES;
				end
			end
			ST_DIVB: begin
				if (sts.div_done) begin
					state_d = ST_RES;
				end
			end
			ST_RES: begin
				if (!sts.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_CLR_BANK: begin
				cmd.sweep_bank = 1'b1;
				if (sts.sweep_end_bank) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR_ALL;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
